/* design/rwfc_pkg.sv */
// shared types, constants and helpers of the register write frame compressor
`default_nettype none
package rwfc_pkg;

  localparam int NUM_REGS  = 14;
  localparam int TIME_BITS = 48;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 8;
  localparam int SKIP_W    = 16;
  localparam int DUR_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPTIMIZE       = 1'd1;

  localparam logic [DUR_W-1:0]  FRAME_DURATION_RST = 24'd20000;
  localparam logic [IDX_W-1:0]  ENV_SHAPE_REG      = 4'd13;
  localparam logic [IDX_W-1:0]  LAST_LINE          = IDX_W'(NUM_REGS - 1);
  localparam logic [SKIP_W-1:0] SKIP_MAX           = 16'hffff;

  localparam logic [VAL_W-1:0] MASK4 = 8'h0f;
  localparam logic [VAL_W-1:0] MASK5 = 8'h1f;
  localparam logic [VAL_W-1:0] MASK8 = 8'hff;

  typedef struct packed {
    logic                 cmd;
    logic                 chunk_start;
    logic [TIME_BITS-1:0] time_stamp;
    logic                 reg_valid;
    logic [IDX_W-1:0]     reg_index;
    logic [VAL_W-1:0]     reg_value;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_reg_index;
    logic              base_valid;
    logic [VAL_W-1:0]  base_value;
    logic              delta_valid;
    logic [VAL_W-1:0]  delta_value;
    logic [SKIP_W-1:0] frames_elapsed;
    logic              last_of_frame;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;
    logic             line_load;
    logic [IDX_W-1:0] line_idx;
    logic             last;
    logic             apply;
  } rwfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic out_free;
  } rwfc_status_t;

  function automatic logic [VAL_W-1:0] width_mask(input logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] m;
    unique case (idx)
      4'd1, 4'd3, 4'd5, 4'd13: m = MASK4;
      4'd6, 4'd8, 4'd9, 4'd10: m = MASK5;
      default:                 m = MASK8;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* design/register_write_frame_compressor_top.sv */
// top level of the register write frame compressor
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_stall  in_beat_t   (cmd, chunk, time, write)
//  out      out  out_valid/out_stall out_beat_t (one line per chip register)
//  cfg      in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// a beat that emits no run is taken in the cycle it is offered, one beat per cycle while idle
// a beat that emits a run is accepted, then the 14 lines are loaded into the
// output register one line per cycle while the output is free, then the deferred
// register write is applied, set by the controller sequencing the rotating register file
// output stall holds the line sequencer; the input stalls until the run is out
// synchronous active-low reset restores the register reset values
`default_nettype none
module register_write_frame_compressor_top
  import rwfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data
);

  // command and status between controller and datapath
  rwfc_cmd_t    cmd;
  rwfc_status_t status;

  // sequencer: idle / emit run / deferred write
  rwfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // register file, frame timing and output register
  rwfc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTH
  // a beat that starts a run must hold off the input next cycle
  a_emit_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && status.emit) |=> in_stall)
    else $error("run start did not stall input");

  // lines are only loaded while the input is held off
  a_load_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.line_load |-> in_stall)
    else $error("line load while input open");

  // the deferred write ends the run and reopens the input
  a_apply_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> !in_stall)
    else $error("input not reopened after run");

  // the last line loaded is immediately followed by the deferred write
  a_last_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.line_load && cmd.last) |=> cmd.apply)
    else $error("last line not followed by write");
`endif

endmodule
`default_nettype wire

/* design/rwfc_ctrl.sv */
// controller of the frame compressor: idle, run emission and deferred write
`default_nettype none
module rwfc_ctrl
  import rwfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire rwfc_status_t status,
  output rwfc_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] line_r, line_nxt;
  logic             accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    cmd.accept    = accept;
    cmd.line_load = 1'b0;
    cmd.line_idx  = line_r;
    cmd.last      = (line_r == LAST_LINE);
    cmd.apply     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && status.emit) begin
          state_nxt = ST_EMIT;
          line_nxt  = '0;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.line_load = 1'b1;
          if (line_r == LAST_LINE) begin
            state_nxt = ST_APPLY;
          end else begin
            line_nxt = line_r + 1'b1;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_r  <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/rwfc_datapath.sv */
// datapath of the frame compressor: register file, frame timing, output register
`default_nettype none
module rwfc_datapath
  import rwfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wdata,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  input  wire rwfc_cmd_t            cmd,
  output rwfc_status_t              status
);

  logic [DUR_W-1:0]     fd_r;
  logic                 opt_r;
  logic [TIME_BITS-1:0] nb_r;
  logic [SKIP_W-1:0]    skip_r;
  logic [SKIP_W-1:0]    frames_r;

  // register file rotates by one entry per emitted line
  logic [VAL_W-1:0]    base_r  [NUM_REGS];
  logic [VAL_W-1:0]    delta_r [NUM_REGS];
  logic [NUM_REGS-1:0] bp_r;
  logic [NUM_REGS-1:0] dp_r;

  logic             pend_valid_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic [VAL_W-1:0] pend_val_r;

  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic              close, emit;
  logic [SKIP_W-1:0] skip_inc;
  logic              wr_en, in_range, cancel;
  logic [IDX_W-1:0]  wr_idx;
  logic [VAL_W-1:0]  wr_val, masked;
  logic              bp0n;
  logic [VAL_W-1:0]  base0n;

  assign close    = !in_data.cmd && in_data.chunk_start && (in_data.time_stamp >= nb_r);
  assign emit     = (in_data.cmd && (skip_r != '0)) || (close && (dp_r != '0));
  assign skip_inc = (skip_r == SKIP_MAX) ? skip_r : skip_r + 1'b1;

  assign status.emit     = emit;
  assign status.out_free = !out_valid_r || !out_stall;

  assign wr_en  = (cmd.accept && !emit && !in_data.cmd && in_data.reg_valid)
               || (cmd.apply && pend_valid_r);
  assign wr_idx = cmd.apply ? pend_idx_r : in_data.reg_index;
  assign wr_val = cmd.apply ? pend_val_r : in_data.reg_value;
  assign in_range = ({1'b0, wr_idx} < (IDX_W + 1)'(NUM_REGS));
  assign masked = wr_val & width_mask(wr_idx);
  assign cancel = in_range && opt_r && (wr_idx != ENV_SHAPE_REG) && bp_r[wr_idx]
               && (base_r[wr_idx] == masked);

  // committed entry at the head of the rotation
  assign bp0n   = bp_r[0] | dp_r[0];
  assign base0n = dp_r[0] ? delta_r[0] : base_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r   <= FRAME_DURATION_RST;
      opt_r  <= 1'b1;
      nb_r   <= TIME_BITS'(FRAME_DURATION_RST);
      skip_r <= '0;
      bp_r   <= '0;
      dp_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_DURATION: fd_r  <= cfg_wdata;
          REG_OPTIMIZE:       opt_r <= cfg_wdata[0];
        endcase
      end
      if (cmd.accept) begin
        if (close) begin
          nb_r <= nb_r + TIME_BITS'(fd_r);
        end
        if (emit) begin
          skip_r       <= '0;
          pend_valid_r <= !in_data.cmd && in_data.reg_valid;
        end else if (close) begin
          skip_r <= skip_inc;
        end
      end
      if (cmd.line_load) begin
        bp_r <= {bp0n, bp_r[NUM_REGS-1:1]};
        dp_r <= {1'b0, dp_r[NUM_REGS-1:1]};
      end else if (wr_en && in_range) begin
        dp_r[wr_idx] <= !cancel;
      end
      if (cmd.apply) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.line_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      frames_r   <= in_data.cmd ? skip_r : skip_inc;
      pend_idx_r <= in_data.reg_index;
      pend_val_r <= in_data.reg_value;
    end
    if (cmd.line_load) begin
      for (int i = 0; i < NUM_REGS - 1; i++) begin
        base_r[i]  <= base_r[i+1];
        delta_r[i] <= delta_r[i+1];
      end
      base_r[NUM_REGS-1]  <= base0n;
      delta_r[NUM_REGS-1] <= '0;
      out_data_r.out_reg_index  <= cmd.line_idx;
      out_data_r.base_valid     <= bp0n;
      out_data_r.base_value     <= bp0n ? base0n : '0;
      out_data_r.delta_valid    <= dp_r[0];
      out_data_r.delta_value    <= dp_r[0] ? delta_r[0] : '0;
      out_data_r.frames_elapsed <= frames_r;
      out_data_r.last_of_frame  <= cmd.last;
    end else if (wr_en && in_range) begin
      delta_r[wr_idx] <= cancel ? '0 : masked;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking testbench of the register write frame compressor
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwfc_pkg::*;

  // clock half period, run lengths and pacing limits
  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 24;   // settle margin after a run
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off
  localparam int QUIET_LIMIT   = 3000; // cycles without any beat before giving up
  localparam int PRINT_CAP     = 50;

  localparam logic [TIME_BITS-1:0] TS_MAX = '1;
  localparam logic [DUR_W-1:0]     DUR_MAX = '1;
  localparam logic [DUR_W-1:0]     DUR_MIN = DUR_W'(1);

  // chip register numbers
  typedef enum logic [IDX_W-1:0] {
    R_A_FINE, R_A_COARSE, R_B_FINE, R_B_COARSE, R_C_FINE, R_C_COARSE,
    R_NOISE, R_MIXER, R_A_LEVEL, R_B_LEVEL, R_C_LEVEL,
    R_ENV_FINE, R_ENV_COARSE, R_ENV_SHAPE
  } chip_reg_e;

  // register numbers past the end of the chip, writes there are dropped
  localparam logic [IDX_W-1:0] R_NONE_LO = IDX_W'(NUM_REGS);
  localparam logic [IDX_W-1:0] R_NONE_HI = '1;

  // tracks the chip image the block should hold and the lines it owes
  class frame_ledger;
    logic [VAL_W-1:0]     base_val [NUM_REGS];
    bit                   base_has [NUM_REGS];
    logic [VAL_W-1:0]     delta_val[NUM_REGS];
    bit                   delta_has[NUM_REGS];
    logic [SKIP_W-1:0]    skipped;
    logic [TIME_BITS-1:0] next_bound;
    logic [DUR_W-1:0]     frame_len;
    bit                   squash_en;
    out_beat_t            lines_due[$];
    int                   errors;

    function new();
      for (int i = 0; i < NUM_REGS; i++) begin
        base_val[i]  = '0;
        base_has[i]  = 1'b0;
        delta_val[i] = '0;
        delta_has[i] = 1'b0;
      end
      frame_len  = FRAME_DURATION_RST;
      squash_en  = 1'b1;
      skipped    = '0;
      next_bound = TIME_BITS'(FRAME_DURATION_RST);
      errors     = 0;
    endfunction

    function logic [VAL_W-1:0] reg_mask(logic [IDX_W-1:0] idx);
      case (idx)
        R_A_COARSE, R_B_COARSE, R_C_COARSE, R_ENV_SHAPE: return MASK4;
        R_NOISE, R_A_LEVEL, R_B_LEVEL, R_C_LEVEL:        return MASK5;
        default:                                         return MASK8;
      endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
      if (idx == REG_FRAME_DURATION) begin
        frame_len = val;
      end else begin
        squash_en = val[0];
      end
    endfunction

    function void apply_write(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] raw);
      logic [VAL_W-1:0] v;
      if (idx >= NUM_REGS) return;
      v = raw & reg_mask(idx);
      // a write back to the committed value cancels the pending change
      if (squash_en && idx != ENV_SHAPE_REG && base_has[idx] && base_val[idx] == v) begin
        delta_has[idx] = 1'b0;
        delta_val[idx] = '0;
      end else begin
        delta_has[idx] = 1'b1;
        delta_val[idx] = v;
      end
    endfunction

    function void commit_run();
      out_beat_t ln;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (delta_has[i]) begin
          base_val[i] = delta_val[i];
          base_has[i] = 1'b1;
        end
        ln                = '0;
        ln.out_reg_index  = IDX_W'(i);
        ln.base_valid     = base_has[i];
        ln.base_value     = base_has[i] ? base_val[i] : '0;
        ln.delta_valid    = delta_has[i];
        ln.delta_value    = delta_has[i] ? delta_val[i] : '0;
        ln.frames_elapsed = skipped;
        ln.last_of_frame  = (i == NUM_REGS - 1);
        lines_due.push_back(ln);
        delta_has[i] = 1'b0;
        delta_val[i] = '0;
      end
      skipped = '0;
    endfunction

    // one accepted input beat
    function void take_beat(in_beat_t b);
      bit any_delta;
      if (b.cmd) begin
        if (skipped != '0) commit_run();
        return;
      end
      if (b.chunk_start && b.time_stamp >= next_bound) begin
        if (skipped != SKIP_MAX) skipped++;
        any_delta = 1'b0;
        for (int i = 0; i < NUM_REGS; i++) any_delta |= delta_has[i];
        if (any_delta) commit_run();
        next_bound = next_bound + TIME_BITS'(frame_len);
      end
      if (b.reg_valid) apply_write(b.reg_index, b.reg_value);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", what);
    endtask

    // one accepted result beat against the oldest owed line
    task check_line(out_beat_t got);
      out_beat_t want;
      string     bad;
      if (lines_due.size() == 0) begin
        report($sformatf("unexpected line %h", got));
        return;
      end
      want = lines_due.pop_front();
      bad  = "";
      if (got.out_reg_index  !== want.out_reg_index)  bad = {bad, " out_reg_index"};
      if (got.base_valid     !== want.base_valid)     bad = {bad, " base_valid"};
      if (got.base_value     !== want.base_value)     bad = {bad, " base_value"};
      if (got.delta_valid    !== want.delta_valid)    bad = {bad, " delta_valid"};
      if (got.delta_value    !== want.delta_value)    bad = {bad, " delta_value"};
      if (got.frames_elapsed !== want.frames_elapsed) bad = {bad, " frames_elapsed"};
      if (got.last_of_frame  !== want.last_of_frame)  bad = {bad, " last_of_frame"};
      if (bad != "") begin
        report($sformatf("line %0d:%s got %h want %h", want.out_reg_index, bad, got, want));
      end
    endtask

    function int pending();
      return lines_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;

  frame_ledger ledger;
  bit          calm;        // no idling on either side while set
  bit          hold_req;    // asks the receiver for one long hold-off
  int          quiet_cycles = 0;

  register_write_frame_compressor_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // receiver: random stalls, none while calm, one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // every result beat is checked as it is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_line(out_data);
  end

  // watchdog: too long with no beat on any port ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_BITS-1:0];
  endfunction

  function automatic in_beat_t mk_write(bit start, logic [TIME_BITS-1:0] ts, bit rv,
                                        logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    in_beat_t b;
    b.cmd         = 1'b0;
    b.chunk_start = start;
    b.time_stamp  = ts;
    b.reg_valid   = rv;
    b.reg_index   = idx;
    b.reg_value   = val;
    return b;
  endfunction

  // flush beat, every other field random since the block ignores them
  function automatic in_beat_t mk_flush();
    logic [63:0] r;
    in_beat_t    b;
    r     = {$urandom, $urandom};
    b     = r[$bits(in_beat_t)-1:0];
    b.cmd = 1'b1;
    return b;
  endfunction

  // chunk time placed around the next frame boundary
  function automatic logic [TIME_BITS-1:0] pick_chunk_time();
    logic [TIME_BITS-1:0] b, d, off;
    int pick;
    b    = ledger.next_bound;
    d    = TIME_BITS'(ledger.frame_len);
    pick = $urandom_range(0, 99);
    if (pick < 45) return b + (rand_time() % (d / 2 + 1));
    if (pick < 65) begin
      off = TIME_BITS'($urandom_range(0, 1000));
      return (off >= b) ? TIME_BITS'(0) : b - 1 - off;
    end
    if (pick < 75) return b;
    if (pick < 85) return b + d * TIME_BITS'($urandom_range(2, 5));
    return rand_time();
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 8) return IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1));
    return IDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  // often the committed value again, with random bits above the register width
  function automatic logic [VAL_W-1:0] pick_value(logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] r;
    r = VAL_W'($urandom);
    if (idx < NUM_REGS && ledger.base_has[idx] && $urandom_range(0, 99) < 40) begin
      return ledger.base_val[idx] | (r & ~ledger.reg_mask(idx));
    end
    return r;
  endfunction

  // offer one beat after a random gap unless calm, hold it until taken
  task automatic send_beat(input in_beat_t b);
    if (!calm) begin
      while ($urandom_range(0, 2) == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.take_beat(b);
  endtask

  // stop offering, wait for every owed line, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ledger.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // chunks of writes with random content, mixed with flushes and stray writes
  task automatic random_traffic(input int n_items, input bit with_holdoff);
    logic [TIME_BITS-1:0] ts;
    logic [IDX_W-1:0]     idx;
    int  sent;
    int  extra;
    bit  held;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      if (with_holdoff && !held && sent >= n_items / 3) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1: send_beat(mk_flush());
        2: begin
          // write outside a chunk start, its time never closes a frame
          idx = pick_index();
          send_beat(mk_write(1'b0, rand_time(), $urandom_range(0, 1), idx, pick_value(idx)));
        end
        default: begin
          ts  = pick_chunk_time();
          idx = pick_index();
          send_beat(mk_write(1'b1, ts, $urandom_range(0, 4) != 0, idx, pick_value(idx)));
          extra = $urandom_range(0, 4);
          repeat (extra) begin
            idx = pick_index();
            send_beat(mk_write(1'b0, ($urandom_range(0, 3) == 0) ? rand_time() : ts,
                               $urandom_range(0, 9) != 0, idx, pick_value(idx)));
            sent++;
          end
        end
      endcase
      sent++;
    end
  endtask

  initial begin : stimulus
    ledger    = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_FRAME_DURATION;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats on the reset settings
    send_beat(mk_flush());                                        // nothing skipped yet, no run
    send_beat(mk_write(1'b1, '0, 1'b1, R_A_FINE, 8'hff));         // before the first boundary
    send_beat(mk_write(1'b0, TS_MAX, 1'b1, R_A_COARSE, 8'hff));   // late time but not a chunk start
    send_beat(mk_write(1'b0, TS_MAX, 1'b1, R_NOISE, 8'hff));
    send_beat(mk_write(1'b0, TS_MAX, 1'b1, R_ENV_SHAPE, 8'hff));
    send_beat(mk_write(1'b0, TS_MAX, 1'b1, R_NONE_LO, 8'h5a));    // past the last register
    send_beat(mk_write(1'b0, TS_MAX, 1'b1, R_NONE_HI, 8'hff));
    send_beat(mk_write(1'b1, ledger.next_bound - 1, 1'b0, R_A_FINE, 8'h00));
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_B_FINE, 8'h00)); // exactly on boundary
    send_beat(mk_write(1'b1, TS_MAX, 1'b1, R_A_FINE, 8'hff));     // big jump closes one frame,
                                                                  // write equal to base cancels
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b0, R_A_FINE, 8'h00)); // empty frame skipped
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_ENV_SHAPE, 8'h0f)); // shape never dropped
    send_beat(mk_flush());                                        // run with two frames elapsed
    send_beat(mk_flush());                                        // nothing pending now
    send_beat(mk_write(1'b0, TIME_BITS'(1) << (TIME_BITS - 1), 1'b1, R_MIXER, 8'haa));
    send_beat(mk_write(1'b0, '0, 1'b1, R_MIXER, 8'h55));          // later write wins
    send_beat(mk_write(1'b1, ledger.next_bound + 3 * TIME_BITS'(ledger.frame_len), 1'b1,
                       R_C_FINE, 8'h80));
    drain();

    // optimization off, shortest frame
    write_reg(REG_OPTIMIZE, '0);
    write_reg(REG_FRAME_DURATION, DUR_MIN);
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_A_FINE, 8'hff)); // kept though equal
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_ENV_FINE, 8'h00));
    send_beat(mk_flush());
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_A_LEVEL, 8'he0)); // masked to zero
    send_beat(mk_flush());
    drain();

    // longest frame, receiver holds off for a while mid-phase
    write_reg(REG_FRAME_DURATION, DUR_MAX);
    write_reg(REG_OPTIMIZE, DUR_W'(1));
    random_traffic(65, 1'b1);
    drain();

    // shortest frame, no optimization, with a pause until all lines are out
    write_reg(REG_FRAME_DURATION, DUR_MIN);
    write_reg(REG_OPTIMIZE, '0);
    random_traffic(32, 1'b0);
    drain();
    random_traffic(33, 1'b0);
    drain();

    // mid-range frame, a stretch with no idling on either side
    write_reg(REG_FRAME_DURATION, DUR_W'($urandom_range(100, 50000)));
    write_reg(REG_OPTIMIZE, DUR_W'($urandom) | DUR_W'(1));
    calm = 1'b1;
    random_traffic(65, 1'b0);
    calm = 1'b0;
    drain();

    // short frame, optimization off with junk in the upper data bits
    write_reg(REG_FRAME_DURATION, DUR_W'(300));
    write_reg(REG_OPTIMIZE, DUR_W'($urandom) & ~DUR_W'(1));
    random_traffic(35, 1'b0);
    drain();

    // a string of skipped frames, then a flush reports them
    write_reg(REG_FRAME_DURATION, DUR_MIN);
    write_reg(REG_OPTIMIZE, DUR_W'(1));
    calm = 1'b1;
    repeat (8) begin
      send_beat(mk_write(1'b1, ledger.next_bound, 1'b0, R_A_FINE, 8'h00));
    end
    send_beat(mk_flush());
    calm = 1'b0;
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b1, R_ENV_COARSE, 8'h11));
    send_beat(mk_write(1'b1, ledger.next_bound, 1'b0, R_A_FINE, 8'h00));
    drain();

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* register_write_frame_compressor_top.f */
design/rwfc_pkg.sv
design/rwfc_ctrl.sv
design/rwfc_datapath.sv
design/register_write_frame_compressor_top.sv
tb/tb.sv
